>>> rtl/core/espw_pkg.sv
// Shared types and constants for the ESP anti-replay window checker.
package espw_pkg;

    localparam int WINDOW_SIZE = 32;
    localparam int SEQ_W       = 32;
    localparam int SPI_W       = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int VERDICT_W   = 3;
    // bit index into the replay bitmap
    localparam int WIN_IDX_W   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    typedef logic [WINDOW_SIZE-1:0] t_bitmap;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_SPI      = 3'd1,
        VERDICT_SEQ_ZERO = 3'd2,
        VERDICT_OLD      = 3'd3,
        VERDICT_DUP      = 3'd4,
        VERDICT_PAYLOAD  = 3'd5
    } t_verdict;

    typedef enum logic {
        CFG_EXPECTED_SPI = 1'b0,
        CFG_BYPASS       = 1'b1
    } t_cfg_index;

endpackage

>>> rtl/core/esp_anti_replay_window.sv
// Inbound ESP acceptance checker: SPI match plus sliding-bitmap replay window.
//
// Input channel: i_in_valid / o_in_stall carries one packet header per
// transaction (SPI, sequence number, payload_ok flag from later checks).
// Output channel: o_out_valid / i_out_stall returns one verdict per packet,
// in order.
// A packet is held in the input register and its verdict in the verdict
// register, where o_out_valid rises. Throughput is one packet per cycle while
// the receiver does not stall: the window check and update is a single
// compare, subtract and shift between the input register and the verdict
// register, and the updated window is visible to the very next packet.
// The input register keeps taking transactions while a verdict waits; once
// both it and the verdict register are full and the receiver stalls,
// o_in_stall rises until the verdict is taken.
// Synchronous active-low reset empties both registers, clears the window
// (top 0, bitmap 0), expected SPI 0 and bypass 0.
// Configuration: write i_cfg_wdata to register i_cfg_index (0 expected SPI,
// 1 bypass) when i_cfg_wr_en is high; only while no packet is in flight.
module esp_anti_replay_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [espw_pkg::SPI_W-1:0]          i_packet_spi,
    input  logic [espw_pkg::SEQ_W-1:0]          i_packet_seq,
    input  logic                                i_payload_ok,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [espw_pkg::VERDICT_W-1:0]      o_verdict,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_index,
    input  logic [espw_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import espw_pkg::*;

    logic [SPI_W-1:0]   r_expected_spi;
    logic               r_bypass;

    logic               r_in_valid;
    logic [SPI_W-1:0]   r_spi;
    logic [SEQ_W-1:0]   r_seq;
    logic               r_ok;

    logic               r_out_valid;
    t_verdict           r_verdict;

    logic [SEQ_W-1:0]   r_top;
    t_bitmap            r_bitmap;

    logic               w_move;
    logic               w_take;
    logic               w_commit;
    t_verdict           w_verdict;
    logic [SEQ_W-1:0]   n_top;
    t_bitmap            n_bitmap;
    logic [SEQ_W-1:0]   w_d_up;
    logic [SEQ_W-1:0]   w_d_dn;
    t_bitmap            w_bit;

    // verdict register frees up when empty or being taken
    assign w_move     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_move;
    assign w_take     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_spi <= '0;
            r_bypass       <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_EXPECTED_SPI: r_expected_spi <= i_cfg_wdata[SPI_W-1:0];
                CFG_BYPASS:       r_bypass       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_spi <= i_packet_spi;
            r_seq <= i_packet_seq;
            r_ok  <= i_payload_ok;
        end
    end

    // window check
    always_comb begin
        w_d_up   = r_seq - r_top;
        w_d_dn   = r_top - r_seq;
        w_bit    = t_bitmap'(1) << w_d_dn[WIN_IDX_W-1:0];
        n_top    = r_top;
        n_bitmap = r_bitmap;
        w_verdict = VERDICT_OK;
        w_commit  = 1'b0;
        if (r_bypass) begin
            w_verdict = VERDICT_OK;
        end else if (r_spi != r_expected_spi) begin
            w_verdict = VERDICT_SPI;
        end else if (r_seq == '0) begin
            w_verdict = VERDICT_SEQ_ZERO;
        end else begin
            if (r_top == '0) begin
                n_top    = r_seq;
                n_bitmap = t_bitmap'(1);
            end else if (r_seq > r_top) begin
                n_top = r_seq;
                if (w_d_up >= SEQ_W'(WINDOW_SIZE)) begin
                    n_bitmap = t_bitmap'(1);
                end else begin
                    n_bitmap = (r_bitmap << w_d_up) | t_bitmap'(1);
                end
            end else if (w_d_dn >= SEQ_W'(WINDOW_SIZE)) begin
                w_verdict = VERDICT_OLD;
            end else if (|(r_bitmap & w_bit)) begin
                w_verdict = VERDICT_DUP;
            end else begin
                n_bitmap = r_bitmap | w_bit;
            end
            if (w_verdict == VERDICT_OK) begin
                if (!r_ok) begin
                    w_verdict = VERDICT_PAYLOAD;
                end else begin
                    w_commit = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_bitmap <= '0;
        end else if (w_move && w_commit) begin
            r_top    <= n_top;
            r_bitmap <= n_bitmap;
        end
    end

    // verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_verdict <= w_verdict;
        end
    end

    // a nonzero top always has its own sequence marked
    a_top_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top != '0) |-> r_bitmap[0])
        else $error("window top set without bit 0 in bitmap");

    a_top_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_top >= $past(r_top)))
        else $error("window top moved backwards");

    a_state_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_move)) |-> ($stable(r_top) && $stable(r_bitmap)))
        else $error("window changed without a packet leaving the input register");

    a_bypass_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_bypass)) |-> ($stable(r_top) && $stable(r_bitmap)))
        else $error("window changed in bypass mode");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the ESP anti-replay window checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import espw_pkg::*;

    typedef struct packed {
        logic [SPI_W-1:0] spi;
        logic [SEQ_W-1:0] seq;
        logic             ok;
    } t_pkt;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic [SPI_W-1:0]      i_packet_spi = '0;
    logic [SEQ_W-1:0]      i_packet_seq = '0;
    logic                  i_payload_ok = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic [VERDICT_W-1:0]  o_verdict;
    logic                  i_cfg_wr_en  = 1'b0;
    logic                  i_cfg_index  = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata  = '0;

    // predictor state and its copy of the registers
    logic [SPI_W-1:0] cfg_spi    = '0;
    logic             cfg_bypass = 1'b0;
    logic [SEQ_W-1:0] win_top    = '0;
    t_bitmap          win_map    = '0;

    t_pkt     pkt_q[$];
    t_verdict verdict_q[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_left      = 0;
    int  err_cnt        = 0;
    bit  in_taken       = 1'b0;

    esp_anti_replay_window u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_packet_spi (i_packet_spi),
        .i_packet_seq (i_packet_seq),
        .i_payload_ok (i_payload_ok),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_verdict    (o_verdict),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // Check order: bypass, SPI, sequence zero, window, payload flag.
    function automatic t_verdict predict_verdict(t_pkt p);
        logic [SEQ_W-1:0] d;
        logic [SEQ_W-1:0] nxt_top;
        t_bitmap          nxt_map;
        nxt_top = win_top;
        nxt_map = win_map;
        if (cfg_bypass)
            return VERDICT_OK;
        if (p.spi != cfg_spi)
            return VERDICT_SPI;
        if (p.seq == '0)
            return VERDICT_SEQ_ZERO;
        if (win_top == '0) begin
            nxt_top = p.seq;
            nxt_map = t_bitmap'(1);
        end else if (p.seq > win_top) begin
            d = p.seq - win_top;
            if (d >= WINDOW_SIZE)
                nxt_map = t_bitmap'(1);
            else
                nxt_map = (win_map << d) | t_bitmap'(1);
            nxt_top = p.seq;
        end else begin
            d = win_top - p.seq;
            if (d >= WINDOW_SIZE)
                return VERDICT_OLD;
            if (win_map[d[WIN_IDX_W-1:0]])
                return VERDICT_DUP;
            nxt_map[d[WIN_IDX_W-1:0]] = 1'b1;
        end
        // window update is dropped when later checks failed
        if (!p.ok)
            return VERDICT_PAYLOAD;
        win_top = nxt_top;
        win_map = nxt_map;
        return VERDICT_OK;
    endfunction

    // input side: accept at rising edge, present new data at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            verdict_q.push_back(predict_verdict(pkt_q[0]));
            void'(pkt_q.pop_front());
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : pkt_drv
        logic nv;
        if (!i_rst_n)
            nv = 1'b0;
        else if (i_in_valid && !in_taken)
            nv = 1'b1;
        else
            nv = (pkt_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        in_taken = 1'b0;
        if (nv) begin
            i_packet_spi <= pkt_q[0].spi;
            i_packet_seq <= pkt_q[0].seq;
            i_payload_ok <= pkt_q[0].ok;
        end
        i_in_valid <= nv;
    end

    // output side stall, with an optional long hold-off
    always @(negedge i_clk) begin : stall_drv
        logic st;
        if (hold_left != 0) begin
            st = 1'b1;
            hold_left = hold_left - 1;
        end else begin
            st = ($urandom_range(99) < recv_stall_pct);
        end
        i_out_stall <= st;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                report_error($sformatf("verdict %0d with no packet pending", o_verdict));
            end else begin
                if (o_verdict !== verdict_q[0])
                    report_error($sformatf("verdict got %0d exp %s",
                                           o_verdict, verdict_q[0].name()));
                void'(verdict_q.pop_front());
            end
        end
    end

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == CFG_EXPECTED_SPI)
            cfg_spi = data[SPI_W-1:0];
        else
            cfg_bypass = data[0];
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pkt_q.size() != 0 || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_pkt(logic [SPI_W-1:0] spi, logic [SEQ_W-1:0] seq, logic ok);
        t_pkt p;
        p.spi = spi;
        p.seq = seq;
        p.ok  = ok;
        pkt_q.push_back(p);
    endtask

    // Mostly sequences around the running top; the rest is noise.
    task automatic add_random(int n);
        t_pkt             p;
        int               r;
        int               delta;
        logic [SEQ_W-1:0] top;
        top = win_top;
        for (int k = 0; k < n; k++) begin
            r     = $urandom_range(99);
            p.spi = cfg_spi;
            p.ok  = ($urandom_range(9) != 0);
            p.seq = top;
            if (cfg_bypass) begin
                p.spi = $urandom();
                p.seq = $urandom();
                p.ok  = $urandom_range(1);
                if (r < 20)
                    p.spi = cfg_spi;
                if (r < 10)
                    p.seq = '0;
            end else if (r < 8) begin
                p.spi = $urandom();
                if (p.spi == cfg_spi)
                    p.spi = p.spi ^ (32'h1 << $urandom_range(31));
                p.seq = $urandom();
                p.ok  = $urandom_range(1);
            end else if (r < 12) begin
                p.seq = '0;
            end else if (r < 22) begin
                p.seq = $urandom();
                p.ok  = 1'b0;
            end else if (r < 72) begin
                delta = $urandom_range(36);
                p.seq = (top > delta) ? top - delta : 32'd1;
            end else if (r < 92) begin
                p.seq = top + $urandom_range(40, 1);
            end else begin
                p.seq = top + $urandom_range(5000, 41);
            end
            // a jump with matching SPI and good payload always commits
            if (!cfg_bypass && p.spi == cfg_spi && p.ok && p.seq > top)
                top = p.seq;
            pkt_q.push_back(p);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, empty window, edges of the window
        add_pkt(32'hFFFF_FFFF, 32'd5, 1'b1);
        add_pkt(32'h0, 32'd0, 1'b1);
        add_pkt(32'h1, 32'd0, 1'b1);
        add_pkt(32'h0, 32'd5, 1'b0);
        add_pkt(32'h0, 32'd5, 1'b1);
        add_pkt(32'h0, 32'd5, 1'b1);
        add_pkt(32'h0, 32'd5, 1'b0);
        add_pkt(32'h0, 32'd4, 1'b1);
        add_pkt(32'h0, 32'd3, 1'b0);
        add_pkt(32'h0, 32'd3, 1'b1);
        add_pkt(32'h0, 32'd37, 1'b1);
        add_pkt(32'h0, 32'd5, 1'b1);
        add_pkt(32'h0, 32'd6, 1'b1);
        add_pkt(32'h0, 32'd6, 1'b1);
        add_pkt(32'h0, 32'd38, 1'b1);
        add_pkt(32'h0, 32'd6, 1'b1);
        add_pkt(32'h0, 32'd7, 1'b1);
        add_pkt(32'h0, 32'd100, 1'b0);
        add_pkt(32'h0, 32'd70, 1'b1);
        add_pkt(32'h0, 32'd39, 1'b1);
        add_pkt(32'h0, 32'd69, 1'b1);
        add_pkt(32'h0, 32'd71, 1'b1);
        wait_idle();

        // upper bits of the bypass write must be ignored
        write_reg(CFG_EXPECTED_SPI, 32'hFFFF_FFFF);
        write_reg(CFG_BYPASS, 32'hFFFF_FFFE);
        send_idle_pct  = 83;
        recv_stall_pct = 0;
        add_random(300);
        wait_idle();

        write_reg(CFG_EXPECTED_SPI, $urandom());
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        add_random(300);
        wait_idle();

        write_reg(CFG_BYPASS, 32'h1);
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        add_random(100);
        wait_idle();

        // receiver holds off while the sender streams
        write_reg(CFG_BYPASS, 32'h0);
        write_reg(CFG_EXPECTED_SPI, 32'h0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_left = 400;
        add_random(300);
        wait_idle();

        write_reg(CFG_EXPECTED_SPI, $urandom());
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        add_random(250);
        // top of the sequence space
        add_pkt(cfg_spi, 32'hFFFF_FFF0, 1'b1);
        add_pkt(cfg_spi, 32'hFFFF_FFFF, 1'b0);
        add_pkt(cfg_spi, 32'hFFFF_FFFF, 1'b1);
        add_pkt(cfg_spi, 32'hFFFF_FFFF, 1'b1);
        add_pkt(cfg_spi, 32'hFFFF_FFE0, 1'b1);
        add_pkt(cfg_spi, 32'hFFFF_FFDF, 1'b1);
        add_pkt(cfg_spi, 32'h0000_0001, 1'b1);
        add_pkt(cfg_spi, 32'hFFFF_FFFE, 1'b1);
        add_pkt(~cfg_spi, 32'hFFFF_FFFE, 1'b1);
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (verdict_q.size() != 0)
            report_error($sformatf("%0d verdicts never arrived", verdict_q.size()));
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
